### design/smx_pkg.sv
// Package for the stack machine execute unit.
// Holds sizes, opcodes, fault codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package smx_pkg;
  localparam int DATA_DEPTH   = 64;
  localparam int RETURN_DEPTH = 32;
  localparam int ADDR_BITS    = 16;
  localparam int REG_COUNT    = 4;

  localparam int DATA_AW = $clog2(DATA_DEPTH);
  localparam int DATA_CW = $clog2(DATA_DEPTH + 1);
  localparam int RET_AW  = $clog2(RETURN_DEPTH);
  localparam int RET_CW  = $clog2(RETURN_DEPTH + 1);
  localparam int REG_AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam logic [7:0] OP_PUSH  = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_DIV   = 8'd4;
  localparam logic [7:0] OP_MUL   = 8'd5;
  localparam logic [7:0] OP_IN    = 8'd6;
  localparam logic [7:0] OP_PRINT = 8'd7;
  localparam logic [7:0] OP_RET   = 8'd9;
  localparam logic [7:0] OP_EXIT  = 8'd10;
  localparam logic [7:0] OP_CALL  = 8'd11;
  localparam logic [7:0] OP_JMP   = 8'd12;
  localparam logic [7:0] OP_JA    = 8'd13;
  localparam logic [7:0] OP_JAE   = 8'd14;
  localparam logic [7:0] OP_JB    = 8'd15;
  localparam logic [7:0] OP_JBE   = 8'd16;
  localparam logic [7:0] OP_JO    = 8'd17;
  localparam logic [7:0] OP_JC    = 8'd18;
  localparam logic [7:0] OP_JE    = 8'd19;
  localparam logic [7:0] OP_JNE   = 8'd20;
  localparam logic [7:0] OP_RPOP  = 8'd32;
  localparam logic [7:0] OP_RPUSH = 8'd33;

  localparam logic [2:0] F_NONE   = 3'd0;
  localparam logic [2:0] F_UNDER  = 3'd1;
  localparam logic [2:0] F_OVER   = 3'd2;
  localparam logic [2:0] F_DIV0   = 3'd3;
  localparam logic [2:0] F_BADREG = 3'd4;
  localparam logic [2:0] F_BADTGT = 3'd5;

  typedef struct packed {
    logic latch;
    logic div_start;
    logic commit;
  } smx_cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_done;
  } smx_status_t;
endpackage

### design/smx_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Imports smx_pkg but uses none of its items.
`timescale 1ns / 1ps
module smx_divider
  import smx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic        busy;
  logic [5:0]  count;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quo[31]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;
endmodule

### design/smx_datapath.sv
// Datapath: stacks, general registers, instruction decode and result register.
// Depends on smx_pkg and smx_divider.
`timescale 1ns / 1ps
module smx_datapath
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  smx_cmd_t             cmd,
  output smx_status_t          status,
  input  logic                 cfg_write_en,
  input  logic [15:0]          cfg_write_data,
  input  logic [7:0]           opcode,
  input  logic [31:0]          operand,
  input  logic [ADDR_BITS-1:0] instr_addr,
  input  logic [31:0]          in_value,
  output logic [ADDR_BITS-1:0] next_addr,
  output logic                 print_valid,
  output logic [31:0]          print_value,
  output logic                 halted,
  output logic [2:0]           fault
);
  logic [31:0]          dmem [DATA_DEPTH];
  logic [ADDR_BITS-1:0] rmem [RETURN_DEPTH];
  logic [31:0]          gregs [REG_COUNT];
  logic [DATA_CW-1:0]   dsp;
  logic [RET_CW-1:0]    rsp;
  logic [15:0]          plen;

  logic [7:0]           op_q;
  logic [31:0]          opnd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [31:0]          inval_q;
  logic [31:0]          top_q;
  logic [31:0]          sec_q;
  logic [ADDR_BITS-1:0] ret_q;

  logic [DATA_CW-1:0]   dsp_m1;
  logic [DATA_CW-1:0]   dsp_m2;
  logic [RET_CW-1:0]    rsp_m1;

  logic                 reg_ok;
  logic                 tgt_ok;
  logic [31:0]          tgt_m1;
  logic [ADDR_BITS:0]   addr_p1;
  logic [ADDR_BITS:0]   addr_p2;
  logic [ADDR_BITS:0]   addr_p3;
  logic                 take;
  logic                 need1;
  logic [ADDR_BITS:0]   nxt;
  logic [2:0]           flt;
  logic                 pv;
  logic                 hlt;
  logic                 d_we;
  logic [DATA_AW-1:0]   d_waddr;
  logic [31:0]          d_wdata;
  logic [DATA_CW-1:0]   dsp_next;
  logic                 r_we;
  logic [RET_CW-1:0]    rsp_next;
  logic                 g_we;
  logic [31:0]          alu;
  logic [31:0]          quo;
  logic                 div_done;

  assign dsp_m1 = dsp - DATA_CW'(1);
  assign dsp_m2 = dsp - DATA_CW'(2);
  assign rsp_m1 = rsp - RET_CW'(1);

  smx_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sec_q),
    .divisor  (top_q),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= opcode;
      opnd_q  <= operand;
      addr_q  <= instr_addr;
      inval_q <= in_value;
      top_q   <= dmem[dsp_m1[DATA_AW-1:0]];
      sec_q   <= dmem[dsp_m2[DATA_AW-1:0]];
      ret_q   <= rmem[rsp_m1[RET_AW-1:0]];
    end
    if (cmd.commit && d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    if (cmd.commit && r_we) begin
      rmem[rsp[RET_AW-1:0]] <= addr_p3[ADDR_BITS-1:0];
    end
  end

  assign reg_ok  = !opnd_q[31] && (opnd_q < 32'(REG_COUNT));
  assign tgt_m1  = opnd_q - 32'd1;
  assign tgt_ok  = !opnd_q[31] && (opnd_q != 32'd0) && ((tgt_m1 >> ADDR_BITS) == 32'd0);
  assign addr_p1 = {1'b0, addr_q} + (ADDR_BITS + 1)'(1);
  assign addr_p2 = {1'b0, addr_q} + (ADDR_BITS + 1)'(2);
  assign addr_p3 = {1'b0, addr_q} + (ADDR_BITS + 1)'(3);

  always_comb begin
    case (op_q)
      OP_JA:   take = $signed(top_q) >  $signed(sec_q);
      OP_JAE:  take = $signed(top_q) >= $signed(sec_q);
      OP_JB:   take = $signed(top_q) <  $signed(sec_q);
      OP_JBE:  take = $signed(top_q) <= $signed(sec_q);
      OP_JO:   take = top_q == 32'd0;
      OP_JC:   take = top_q == 32'd1;
      OP_JE:   take = top_q == sec_q;
      default: take = top_q != sec_q;
    endcase
    need1 = (op_q == OP_JO) || (op_q == OP_JC);

    case (op_q)
      OP_ADD:  alu = sec_q + top_q;
      OP_SUB:  alu = sec_q - top_q;
      OP_MUL:  alu = sec_q * top_q;
      default: alu = quo;
    endcase
  end

  always_comb begin
    flt      = F_NONE;
    nxt      = addr_p1;
    pv       = 1'b0;
    d_we     = 1'b0;
    d_waddr  = dsp[DATA_AW-1:0];
    d_wdata  = alu;
    dsp_next = dsp;
    r_we     = 1'b0;
    rsp_next = rsp;
    g_we     = 1'b0;
    case (op_q)
      OP_PUSH, OP_IN: begin
        if (dsp >= DATA_CW'(DATA_DEPTH)) begin
          flt = F_OVER;
        end else begin
          d_we     = 1'b1;
          d_wdata  = (op_q == OP_PUSH) ? opnd_q : inval_q;
          dsp_next = dsp + DATA_CW'(1);
          if (op_q == OP_PUSH) begin
            nxt = addr_p2;
          end
        end
      end
      OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
        if (dsp < DATA_CW'(2)) begin
          flt = F_UNDER;
        end else if (op_q == OP_DIV && top_q == 32'd0) begin
          flt = F_DIV0;
        end else begin
          d_we     = 1'b1;
          d_waddr  = dsp_m2[DATA_AW-1:0];
          dsp_next = dsp_m1;
        end
      end
      OP_PRINT: begin
        if (dsp == '0) begin
          flt = F_UNDER;
        end else begin
          pv = 1'b1;
        end
      end
      OP_RET: begin
        if (rsp == '0) begin
          flt = F_UNDER;
        end else if (ret_q == '0) begin
          flt = F_BADTGT;
        end else begin
          rsp_next = rsp_m1;
          nxt      = {1'b0, ret_q} - (ADDR_BITS + 1)'(1);
        end
      end
      OP_EXIT: begin
        nxt = {1'b0, addr_q};
      end
      OP_CALL: begin
        if (rsp >= RET_CW'(RETURN_DEPTH)) begin
          flt = F_OVER;
        end else if (!tgt_ok || addr_p3[ADDR_BITS]) begin
          flt = F_BADTGT;
        end else begin
          r_we     = 1'b1;
          rsp_next = rsp + RET_CW'(1);
          nxt      = {1'b0, tgt_m1[ADDR_BITS-1:0]};
        end
      end
      OP_JMP: begin
        if (!tgt_ok) begin
          flt = F_BADTGT;
        end else begin
          nxt = {1'b0, tgt_m1[ADDR_BITS-1:0]};
        end
      end
      OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JO, OP_JC, OP_JE, OP_JNE: begin
        if (dsp < (need1 ? DATA_CW'(1) : DATA_CW'(2))) begin
          flt = F_UNDER;
        end else if (take && !tgt_ok) begin
          flt = F_BADTGT;
        end else begin
          dsp_next = need1 ? dsp_m1 : dsp_m2;
          nxt      = take ? {1'b0, tgt_m1[ADDR_BITS-1:0]} : addr_p2;
        end
      end
      OP_RPOP: begin
        if (!reg_ok) begin
          flt = F_BADREG;
        end else if (dsp == '0) begin
          flt = F_UNDER;
        end else begin
          g_we     = 1'b1;
          dsp_next = dsp_m1;
          nxt      = addr_p2;
        end
      end
      OP_RPUSH: begin
        if (!reg_ok) begin
          flt = F_BADREG;
        end else if (dsp >= DATA_CW'(DATA_DEPTH)) begin
          flt = F_OVER;
        end else begin
          d_we     = 1'b1;
          d_wdata  = gregs[opnd_q[REG_AW-1:0]];
          dsp_next = dsp + DATA_CW'(1);
          nxt      = addr_p2;
        end
      end
      default: begin
      end
    endcase
    if (flt != F_NONE) begin
      nxt = {1'b0, addr_q};
      hlt = 1'b0;
    end else if (op_q == OP_EXIT) begin
      hlt = 1'b1;
    end else begin
      hlt = nxt >= (ADDR_BITS + 1)'(plen);
    end
  end

  assign status.div_go   = (op_q == OP_DIV) && (flt == F_NONE);
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      dsp  <= '0;
      rsp  <= '0;
      plen <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        gregs[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        plen <= cfg_write_data;
      end
      if (cmd.commit) begin
        dsp <= dsp_next;
        rsp <= rsp_next;
        if (g_we) begin
          gregs[opnd_q[REG_AW-1:0]] <= top_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      next_addr   <= nxt[ADDR_BITS-1:0];
      print_valid <= pv;
      print_value <= pv ? top_q : 32'd0;
      halted      <= hlt;
      fault       <= flt;
    end
  end
endmodule

### design/smx_controller.sv
// Controller state machine: accepts an instruction, sequences execution and
// owns the result valid. Depends on smx_pkg.
`timescale 1ns / 1ps
module smx_controller
  import smx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  smx_status_t status,
  output smx_cmd_t    cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    cmd.latch     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.div_go) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result overwritten while held");
  a_latch_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == S_EXEC)
    else $error("accepted beat did not enter execution");
  a_div_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_done) |=> state == S_FIN)
    else $error("divide completion missed");
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise result valid");
endmodule

### design/stack_machine_execute_unit.sv
// Stack machine execute unit: one instruction per beat, one result per beat.
// An instruction is latched in the idle state and committed to the result registers in the execute state;
// a divide instead starts the 32-step divider, waits for it, then commits in the finish state.
// A commit waits while a held result is stalled, and no new instruction is accepted until commit.
// Reset clears stack depths, general registers and program_length.
// Depends on smx_pkg, smx_controller and smx_datapath.
`timescale 1ns / 1ps
module stack_machine_execute_unit
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [15:0]          cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           opcode,
  input  logic [31:0]          operand,
  input  logic [ADDR_BITS-1:0] instr_addr,
  input  logic [31:0]          in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_BITS-1:0] next_addr,
  output logic                 print_valid,
  output logic [31:0]          print_value,
  output logic                 halted,
  output logic [2:0]           fault
);
  smx_cmd_t    cmd;
  smx_status_t status;

  smx_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  smx_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .opcode         (opcode),
    .operand        (operand),
    .instr_addr     (instr_addr),
    .in_value       (in_value),
    .next_addr      (next_addr),
    .print_valid    (print_valid),
    .print_value    (print_value),
    .halted         (halted),
    .fault          (fault)
  );
endmodule

### tb/sv/smx_checker.sv
// Checker for the stack machine execute unit: watches both channels,
// predicts each result from its own copy of the stacks and registers, and compares.
// Depends on smx_pkg.
`timescale 1ns / 1ps
module smx_checker
  import smx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [15:0]          cfg_write_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           opcode,
  input  logic [31:0]          operand,
  input  logic [ADDR_BITS-1:0] instr_addr,
  input  logic [31:0]          in_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ADDR_BITS-1:0] next_addr,
  input  logic                 print_valid,
  input  logic [31:0]          print_value,
  input  logic                 halted,
  input  logic [2:0]           fault,
  output int                   errors,
  output int                   pending,
  output int                   prints_seen,
  output int                   faults_seen
);
  typedef struct packed {
    logic [ADDR_BITS-1:0] nxt;
    logic                 pv;
    logic [31:0]          pval;
    logic                 halt;
    logic [2:0]           flt;
  } exec_result_t;

  logic [31:0] dstack [DATA_DEPTH];
  int          ddepth;
  logic [16:0] rstack [RETURN_DEPTH];
  int          rdepth;
  logic [31:0] gregs [REG_COUNT];
  logic [15:0] prog_len;
  exec_result_t expected_q[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic tgt_ok(input logic signed [31:0] t);
    return t >= 1 && (64'(t) - 1) <= 64'((1 << ADDR_BITS) - 1);
  endfunction

  function automatic exec_result_t execute(input logic [7:0] op, input logic [31:0] opd,
                                           input logic [15:0] addr, input logic [31:0] inv);
    exec_result_t r;
    logic [17:0] nx;
    logic signed [31:0] a, b, tp, sc;
    logic take;
    int need;
    nx = addr + 1;
    r = '0;
    case (op)
      OP_PUSH, OP_IN: begin
        if (ddepth >= DATA_DEPTH) r.flt = F_OVER;
        else begin
          dstack[ddepth] = (op == OP_PUSH) ? opd : inv;
          ddepth++;
          if (op == OP_PUSH) nx = addr + 2;
        end
      end
      OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
        if (ddepth < 2) r.flt = F_UNDER;
        else begin
          b = dstack[ddepth-1];
          a = dstack[ddepth-2];
          if (op == OP_DIV && b == 0) r.flt = F_DIV0;
          else begin
            ddepth--;
            case (op)
              OP_ADD: dstack[ddepth-1] = a + b;
              OP_SUB: dstack[ddepth-1] = a - b;
              OP_MUL: dstack[ddepth-1] = a * b;
              default: dstack[ddepth-1] = (a == 32'sh80000000 && b == -1) ? a : a / b;
            endcase
          end
        end
      end
      OP_PRINT: begin
        if (ddepth < 1) r.flt = F_UNDER;
        else begin
          r.pv = 1;
          r.pval = dstack[ddepth-1];
        end
      end
      OP_RET: begin
        if (rdepth < 1) r.flt = F_UNDER;
        else if (rstack[rdepth-1] == 0) r.flt = F_BADTGT;
        else begin
          rdepth--;
          nx = rstack[rdepth] - 1;
        end
      end
      OP_EXIT: begin
        r.halt = 1;
        nx = addr;
      end
      OP_CALL: begin
        if (rdepth >= RETURN_DEPTH) r.flt = F_OVER;
        else if (!tgt_ok(opd) || 32'(addr) + 3 > 32'hFFFF) r.flt = F_BADTGT;
        else begin
          rstack[rdepth] = addr + 3;
          rdepth++;
          nx = opd - 1;
        end
      end
      OP_JMP: begin
        if (!tgt_ok(opd)) r.flt = F_BADTGT;
        else nx = opd - 1;
      end
      OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JO, OP_JC, OP_JE, OP_JNE: begin
        need = (op == OP_JO || op == OP_JC) ? 1 : 2;
        if (ddepth < need) r.flt = F_UNDER;
        else begin
          tp = dstack[ddepth-1];
          sc = (need == 2) ? dstack[ddepth-2] : 0;
          case (op)
            OP_JA:   take = tp > sc;
            OP_JAE:  take = tp >= sc;
            OP_JB:   take = tp < sc;
            OP_JBE:  take = tp <= sc;
            OP_JO:   take = tp == 0;
            OP_JC:   take = tp == 1;
            OP_JE:   take = tp == sc;
            default: take = tp != sc;
          endcase
          if (take && !tgt_ok(opd)) r.flt = F_BADTGT;
          else begin
            ddepth -= need;
            nx = take ? 18'(opd - 1) : 18'(addr + 2);
          end
        end
      end
      OP_RPOP: begin
        if ($signed(opd) < 0 || $signed(opd) >= REG_COUNT) r.flt = F_BADREG;
        else if (ddepth < 1) r.flt = F_UNDER;
        else begin
          ddepth--;
          gregs[opd] = dstack[ddepth];
          nx = addr + 2;
        end
      end
      OP_RPUSH: begin
        if ($signed(opd) < 0 || $signed(opd) >= REG_COUNT) r.flt = F_BADREG;
        else if (ddepth >= DATA_DEPTH) r.flt = F_OVER;
        else begin
          dstack[ddepth] = gregs[opd];
          ddepth++;
          nx = addr + 2;
        end
      end
      default: ;
    endcase
    if (r.flt != F_NONE) begin
      nx = addr;
      r.pv = 0;
      r.pval = 0;
      r.halt = 0;
    end else if (!r.halt && nx >= prog_len) begin
      r.halt = 1;
    end
    r.nxt = nx[15:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    exec_result_t w;
    if (rst) begin
      ddepth = 0;
      rdepth = 0;
      prog_len = 0;
      errors = 0;
      prints_seen = 0;
      faults_seen = 0;
      for (int i = 0; i < REG_COUNT; i++) gregs[i] = 0;
      expected_q.delete();
    end else begin
      if (cfg_write_en) prog_len = cfg_write_data;
      if (in_valid && !in_stall)
        expected_q.push_back(execute(opcode, operand, instr_addr, in_value));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("MISMATCH: result beat with nothing expected at %0t", $realtime);
          errors++;
        end else begin
          w = expected_q.pop_front();
          if (next_addr !== w.nxt) report("next_addr", next_addr, w.nxt);
          if (print_valid !== w.pv) report("print_valid", print_valid, w.pv);
          if (print_value !== w.pval) report("print_value", print_value, w.pval);
          if (halted !== w.halt) report("halted", halted, w.halt);
          if (fault !== w.flt) report("fault", fault, w.flt);
          if (w.pv) prints_seen++;
          if (w.flt != F_NONE) faults_seen++;
        end
      end
    end
  end
endmodule

### tb/sv/testbench.sv
// Top of the stack machine execute unit testbench: clock, reset, stimulus and verdict.
// Depends on smx_pkg, stack_machine_execute_unit and smx_checker.
`timescale 1ns / 1ps
module testbench;
  import smx_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write_en = 0;
  logic [15:0] cfg_write_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] opcode = 0;
  logic [31:0] operand = 0;
  logic [ADDR_BITS-1:0] instr_addr = 0;
  logic [31:0] in_value = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [ADDR_BITS-1:0] next_addr;
  logic print_valid;
  logic [31:0] print_value;
  logic halted;
  logic [2:0] fault;
  int errors, pending, prints_seen, faults_seen;
  int send_idle_pct = 27;
  int recv_idle_pct = 63;
  int beats_sent = 0;

  always #5 clk = ~clk;

  stack_machine_execute_unit DUT (.*);
  smx_checker u_checker (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send(input logic [7:0] op, input logic [31:0] opd,
                      input logic [15:0] addr, input logic [31:0] inv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    opcode <= op;
    operand <= opd;
    instr_addr <= addr;
    in_value <= inv;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_length(input logic [15:0] len);
    drain();
    cfg_write_en <= 1;
    cfg_write_data <= len;
    @(posedge clk);
    cfg_write_en <= 0;
  endtask

  function automatic logic [7:0] pick_op();
    logic [7:0] ops [21] = '{OP_PUSH, OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_IN, OP_PRINT,
                             OP_RET, OP_EXIT, OP_CALL, OP_JMP, OP_JA, OP_JAE, OP_JB,
                             OP_JBE, OP_JO, OP_JC, OP_JE, OP_JNE, OP_RPOP, OP_RPUSH};
    int k;
    k = $urandom_range(99);
    if (k < 4) return 8'($urandom);
    if (k < 30) return OP_PUSH;
    if (k < 36) return OP_IN;
    return ops[$urandom_range(20)];
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'hFFFFFFFF;
      3, 4: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_operand(input logic [7:0] op);
    int k;
    k = $urandom_range(9);
    if (op == OP_RPOP || op == OP_RPUSH)
      return (k < 8) ? 32'($urandom_range(REG_COUNT - 1)) : pick_value();
    if (op >= OP_CALL && op <= OP_JNE)
      return (k < 8) ? 32'($urandom_range(65536, 1)) : pick_value();
    return pick_value();
  endfunction

  task automatic random_phase(input int count);
    logic [7:0] op;
    for (int i = 0; i < count; i++) begin
      op = pick_op();
      send(op, pick_operand(op),
           ($urandom_range(9) == 0) ? 16'(32'hFFFF - $urandom_range(3)) : 16'($urandom),
           pick_value());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_length(16'hFFFF);
    // Underflows on an empty machine, then arithmetic corners, divide by zero, bad registers and targets.
    send(OP_ADD, 0, 10, 0);
    send(OP_PRINT, 0, 11, 0);
    send(OP_RET, 0, 12, 0);
    send(OP_PUSH, 32'h80000000, 0, 0);
    send(OP_IN, 0, 16'hFFFF, 32'hFFFFFFFF);
    send(OP_DIV, 0, 20, 0);
    send(OP_PUSH, 0, 21, 0);
    send(OP_DIV, 0, 22, 0);
    send(OP_RPOP, 32'hFFFFFFFF, 23, 0);
    send(OP_RPOP, 4, 24, 0);
    send(OP_RPOP, 3, 25, 0);
    send(OP_RPUSH, 3, 26, 0);
    send(OP_MUL, 0, 27, 0);
    send(OP_PRINT, 0, 28, 0);
    send(OP_JMP, 0, 29, 0);
    send(OP_JMP, 32'h10000, 30, 0);
    send(OP_JMP, 32'h10001, 31, 0);
    send(OP_CALL, 5, 16'hFFFD, 0);
    send(OP_CALL, 100, 16'hFFFC, 0);
    send(OP_RET, 0, 40, 0);
    send(OP_EXIT, 0, 41, 0);
    send(8'd255, 32'h7FFFFFFF, 42, 32'h7FFFFFFF);
    send(OP_JO, 7, 43, 0);
    set_length(0);
    send(8'd0, 0, 0, 0);
    set_length(16'd300);
    random_phase(120);
    // Fill the data stack to overflow, then fill the return stack to overflow and return from it.
    for (int i = 0; i < DATA_DEPTH + 1; i++) send(OP_PUSH, $urandom, 16'(i), 0);
    for (int i = 0; i < RETURN_DEPTH + 1; i++) send(OP_CALL, 50, 16'(i), 0);
    for (int i = 0; i < RETURN_DEPTH + 1; i++) send(OP_RET, 0, 16'(i), 0);
    random_phase(100);
    set_length(16'h8000);
    send_idle_pct = 63;
    recv_idle_pct = 27;
    random_phase(200);
    set_length(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(150);
    drain();
    $display("Sent %0d instructions over four program lengths; %0d prints and %0d faults checked.",
             beats_sent, prints_seen, faults_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule

### filelist.f
design/smx_pkg.sv
design/smx_divider.sv
design/smx_datapath.sv
design/smx_controller.sv
design/stack_machine_execute_unit.sv
tb/sv/smx_checker.sv
tb/sv/testbench.sv
